/* rtl/sida_pkg.sv */
// package for the signed integer to decimal ascii converter
// holds the width constants, the sequencer state type and character constants; no dependencies
package sida_pkg;

    localparam int ValueWidth = 32;
    localparam int NumDigits  = 10;
    localparam int BcdWidth   = 4 * NumDigits;

    localparam logic [7:0] CharZero  = 8'd48;
    localparam logic [7:0] CharMinus = 8'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } sida_state_t;

endpackage

/* rtl/signed_int_to_decimal_ascii.sv */
// signed 32-bit integer to decimal ascii text, one character per output transaction
// depends on sida_pkg
//
// One value is taken per input transaction and its decimal text leaves most
// significant character first, a minus sign ahead of negative values, with last
// set on the final character. The magnitude goes through a shift-and-add-3
// binary to BCD unit that handles one bit per cycle, then leading zero digits
// are dropped one per cycle, then one character leaves per cycle while the
// output register is free (empty or being taken). in_ready is high only while
// the sequencer is idle, and a new value may be taken while the final character
// still waits in the output register.
module signed_int_to_decimal_ascii (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [sida_pkg::ValueWidth-1:0] value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       character,
    output logic                             last
);
    import sida_pkg::*;

    sida_state_t state_reg, state_next;

    logic [ValueWidth-1:0] bin_reg, bin_next;
    logic [BcdWidth-1:0]   bcd_reg, bcd_next;
    logic                  neg_reg, neg_next;
    logic [4:0]            count_reg, count_next;
    logic [3:0]            left_reg, left_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            char_reg, char_next;
    logic                  last_reg, last_next;

    logic [BcdWidth-1:0]   bcd_adj;
    logic [3:0]            dig;
    logic                  out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NumDigits; i++)
        begin
            dig = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        neg_reg   <= neg_next;
        count_reg <= count_next;
        left_reg  <= left_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next   = value[ValueWidth-1];
                    bin_next   = value[ValueWidth-1] ? (~value) + 1'b1 : value;
                    bcd_next   = '0;
                    count_next = 5'(ValueWidth - 1);
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                bcd_next   = {bcd_adj[BcdWidth-2:0], bin_reg[ValueWidth-1]};
                bin_next   = {bin_reg[ValueWidth-2:0], 1'b0};
                count_next = count_reg - 5'd1;
                if (count_reg == 5'd0)
                begin
                    left_next  = 4'(NumDigits);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (bcd_reg[BcdWidth-1 -: 4] == 4'd0 && left_reg != 4'd1)
                begin
                    bcd_next  = {bcd_reg[BcdWidth-5:0], 4'd0};
                    left_next = left_reg - 4'd1;
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    char_next      = CharMinus;
                    last_next      = 1'b0;
                    out_valid_next = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    char_next      = CharZero + {4'd0, bcd_reg[BcdWidth-1 -: 4]};
                    last_next      = (left_reg == 4'd1);
                    out_valid_next = 1'b1;
                    bcd_next       = {bcd_reg[BcdWidth-5:0], 4'd0};
                    left_next      = left_reg - 4'd1;
                    if (left_reg == 4'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
